### design/ps2m_pkg.sv
// shared types and constants for the ps/2 mouse packet decoder
package ps2m_pkg;

   // field widths fixed by the byte format
   localparam int BYTE_W   = 8;
   localparam int WHEEL_W  = 2;
   localparam int BTN_W    = 3;
   localparam int BOUND_W  = 13;
   localparam int CSR_ADDR_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_WHEEL_MODE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BOUND_WIDTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BOUND_HEIGHT = 2'd2;

   // register reset values
   localparam logic [BOUND_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [BOUND_W-1:0] HEIGHT_RESET = 13'd480;

   // first-byte format: sync bit, overflow bits, button bits
   localparam int SYNC_BIT = 3;

   // wheel nibble codes and their decoded steps
   localparam logic [3:0] WHEEL_NIB_UP   = 4'h1;
   localparam logic [3:0] WHEEL_NIB_DOWN = 4'hF;
   localparam logic [WHEEL_W-1:0] WHEEL_NONE = 2'b00;
   localparam logic [WHEEL_W-1:0] WHEEL_POS  = 2'b01;
   localparam logic [WHEEL_W-1:0] WHEEL_NEG  = 2'b11;

   // packet queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // one assembled packet, overflow already filtered
   typedef struct packed {
      logic [BTN_W-1:0]   buttons;
      logic [BYTE_W-1:0]  dx;
      logic [BYTE_W-1:0]  dy;
      logic [WHEEL_W-1:0] wheel;
   } pkt_type;

   // configuration seen by the back end
   typedef struct packed {
      logic               recentre;
      logic [BOUND_W-1:0] bound_w;
      logic [BOUND_W-1:0] bound_h;
   } cfg_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

### design/ps2m_front.sv
// front end: byte sync, packet assembly, overflow filter, wheel decode
module ps2m_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ps2m_pkg::BYTE_W-1:0]   in_byte,
   input  logic                          wheel_mode,
   output logic                          push,
   output ps2m_pkg::pkt_type             push_pkt
);

   logic [1:0]                        byte_index_ff, byte_index_in;
   logic [ps2m_pkg::BYTE_W-1:0]       pkt0_ff, pkt0_in;
   logic [ps2m_pkg::BYTE_W-1:0]       pkt1_ff, pkt1_in;
   logic [ps2m_pkg::BYTE_W-1:0]       pkt2_ff, pkt2_in;
   logic                              last_byte;
   logic                              skip_byte;
   logic [ps2m_pkg::WHEEL_W-1:0]      wheel_dec;

   // wheel nibble decode
   always_comb begin
      unique case (in_byte[3:0])
         ps2m_pkg::WHEEL_NIB_UP:   wheel_dec = ps2m_pkg::WHEEL_POS;
         ps2m_pkg::WHEEL_NIB_DOWN: wheel_dec = ps2m_pkg::WHEEL_NEG;
         default:                  wheel_dec = ps2m_pkg::WHEEL_NONE;
      endcase
   end

   // packet assembly
   always_comb begin
      byte_index_in = byte_index_ff;
      pkt0_in       = pkt0_ff;
      pkt1_in       = pkt1_ff;
      pkt2_in       = pkt2_ff;
      push          = 1'b0;
      last_byte     = wheel_mode ? (byte_index_ff == 2'd3) : (byte_index_ff >= 2'd2);
      skip_byte     = (byte_index_ff == 2'd0) && !in_byte[ps2m_pkg::SYNC_BIT];
      if (accept && !skip_byte) begin
         if (!last_byte) begin
            case (byte_index_ff)
               2'd0:    pkt0_in = in_byte;
               2'd1:    pkt1_in = in_byte;
               default: pkt2_in = in_byte;
            endcase
            byte_index_in = byte_index_ff + 2'd1;
         end else begin
            byte_index_in = 2'd0;
            if (!wheel_mode) begin
               pkt2_in = in_byte;
            end
            // drop packets with x or y overflow
            push = (pkt0_ff[7:6] == 2'b00);
         end
      end
   end

   // packet handed to the queue
   always_comb begin
      push_pkt.buttons = pkt0_ff[ps2m_pkg::BTN_W-1:0];
      push_pkt.dx      = pkt1_ff;
      push_pkt.dy      = wheel_mode ? pkt2_ff : in_byte;
      push_pkt.wheel   = wheel_mode ? wheel_dec : ps2m_pkg::WHEEL_NONE;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 2'd0;
      end else begin
         byte_index_ff <= byte_index_in;
      end
   end

   // packet bytes
   always_ff @(posedge clock) begin
      pkt0_ff <= pkt0_in;
      pkt1_ff <= pkt1_in;
      pkt2_ff <= pkt2_in;
   end

endmodule

### design/ps2m_fifo.sv
// short packet queue between front and back end
module ps2m_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ps2m_pkg::pkt_type        push_pkt,
   input  logic                     pop,
   output ps2m_pkg::pkt_type        pop_pkt,
   output ps2m_pkg::fifo_stat_type  stat
);

   ps2m_pkg::pkt_type                     mem_ff [ps2m_pkg::FIFO_DEPTH];
   logic [ps2m_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ps2m_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ps2m_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign stat.full  = (count_ff == ps2m_pkg::FIFO_CNT_W'(ps2m_pkg::FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_pkt    = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      do_push   = push && !stat.full;
      do_pop    = pop && !stat.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + ps2m_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + ps2m_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + ps2m_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ps2m_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

### design/ps2m_back.sv
// back end: cursor move and clamp, button edges, result register
module ps2m_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ps2m_pkg::cfg_type             cfg,
   input  logic                          q_valid,
   input  ps2m_pkg::pkt_type             q_pkt,
   output logic                          pop,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic [COORD_BITS-1:0]         pos_x,
   output logic [COORD_BITS-1:0]         pos_y,
   output logic [ps2m_pkg::BYTE_W-1:0]   delta_x,
   output logic [ps2m_pkg::BYTE_W-1:0]   delta_y,
   output logic [ps2m_pkg::WHEEL_W-1:0]  wheel_step,
   output logic [ps2m_pkg::BTN_W-1:0]    button_mask,
   output logic [ps2m_pkg::BTN_W-1:0]    pressed_mask,
   output logic [ps2m_pkg::BTN_W-1:0]    released_mask
);

   localparam int EFF_W = COORD_BITS + 1;
   localparam int SUM_W = COORD_BITS + 2;
   localparam int CMP_W = (EFF_W > ps2m_pkg::BOUND_W) ? EFF_W : ps2m_pkg::BOUND_W;
   localparam logic [CMP_W-1:0] LIM = CMP_W'(1) << COORD_BITS;

   // bound of zero acts as one, bound above the range saturates
   function automatic logic [EFF_W-1:0] eff_bound(input logic [ps2m_pkg::BOUND_W-1:0] b);
      logic [CMP_W-1:0] bw;
      bw = CMP_W'(b);
      if (bw == '0) begin
         eff_bound = EFF_W'(1);
      end else if (bw > LIM) begin
         eff_bound = LIM[EFF_W-1:0];
      end else begin
         eff_bound = bw[EFF_W-1:0];
      end
   endfunction

   // clamp a signed sum to 0 .. hi
   function automatic logic [COORD_BITS-1:0] clamp_axis(input logic [SUM_W-1:0] v,
                                                        input logic [COORD_BITS-1:0] hi);
      if (v[SUM_W-1]) begin
         clamp_axis = '0;
      end else if (v[SUM_W-2:0] > EFF_W'(hi)) begin
         clamp_axis = hi;
      end else begin
         clamp_axis = v[COORD_BITS-1:0];
      end
   endfunction

   logic                           out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]          cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]          cursor_y_ff, cursor_y_in;
   logic [ps2m_pkg::BTN_W-1:0]     last_btn_ff, last_btn_in;
   logic [COORD_BITS-1:0]          pos_x_ff, pos_y_ff;
   logic [ps2m_pkg::BYTE_W-1:0]    dx_ff, dy_ff;
   logic [ps2m_pkg::WHEEL_W-1:0]   wheel_ff;
   logic [ps2m_pkg::BTN_W-1:0]     btn_ff, pressed_ff, released_ff;
   logic [EFF_W-1:0]               eff_w, eff_h;
   logic [COORD_BITS-1:0]          hi_x, hi_y;
   logic [SUM_W-1:0]               sum_x, sum_y;
   logic [COORD_BITS-1:0]          new_x, new_y;

   // effective bounds and upper limits
   always_comb begin
      eff_w = eff_bound(cfg.bound_w);
      eff_h = eff_bound(cfg.bound_h);
      hi_x  = COORD_BITS'(eff_w - EFF_W'(1));
      hi_y  = COORD_BITS'(eff_h - EFF_W'(1));
   end

   // cursor move, screen y grows downward
   always_comb begin
      sum_x = {2'b00, cursor_x_ff} + {{(SUM_W-ps2m_pkg::BYTE_W){q_pkt.dx[7]}}, q_pkt.dx};
      sum_y = {2'b00, cursor_y_ff} - {{(SUM_W-ps2m_pkg::BYTE_W){q_pkt.dy[7]}}, q_pkt.dy};
      new_x = clamp_axis(sum_x, hi_x);
      new_y = clamp_axis(sum_y, hi_y);
   end

   // pop and state update
   always_comb begin
      pop          = q_valid && (!out_valid_ff || out_ready);
      out_valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      last_btn_in  = last_btn_ff;
      if (cfg.recentre) begin
         cursor_x_in = eff_w[COORD_BITS:1];
         cursor_y_in = eff_h[COORD_BITS:1];
      end else if (pop) begin
         cursor_x_in = new_x;
         cursor_y_in = new_y;
      end
      if (pop) begin
         last_btn_in = q_pkt.buttons;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         last_btn_ff  <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         last_btn_ff  <= last_btn_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (pop) begin
         pos_x_ff    <= new_x;
         pos_y_ff    <= new_y;
         dx_ff       <= q_pkt.dx;
         dy_ff       <= ps2m_pkg::BYTE_W'(8'd0 - q_pkt.dy);
         wheel_ff    <= q_pkt.wheel;
         btn_ff      <= q_pkt.buttons;
         pressed_ff  <= q_pkt.buttons & ~last_btn_ff;
         released_ff <= last_btn_ff & ~q_pkt.buttons;
      end
   end

   assign out_valid     = out_valid_ff;
   assign pos_x         = pos_x_ff;
   assign pos_y         = pos_y_ff;
   assign delta_x       = dx_ff;
   assign delta_y       = dy_ff;
   assign wheel_step    = wheel_ff;
   assign button_mask   = btn_ff;
   assign pressed_mask  = pressed_ff;
   assign released_mask = released_ff;

endmodule

### design/ps2_mouse_packet_decoder.sv
// top level of the ps/2 mouse packet decoder
//
// Raw mouse bytes enter on the req_ stream, one byte per word. The front end
// resyncs on the first-byte marker bit, assembles 3-byte packets (4-byte with
// wheel_mode set), drops packets with an overflow flag and queues the rest.
// The back end moves and clamps the cursor, forms button press and release
// masks and holds one event word on the rsp_ stream.
// Throughput: one byte per cycle; req_tready drops only while the two-entry
// packet queue is full, which happens only when rsp_tready stays low.
// A packet is written into the queue on the edge that takes its last byte and
// moves into the result register when the back end pops it; the back end
// moves one packet per cycle while the event word is taken or none is held.
// The csr_ port writes wheel_mode, bound_width and bound_height; a bound
// write sets a registered recentre flag, which then moves the cursor to the
// centre of the new bounds. Write only while the block is idle.
// Reset clears the packet position, the queue, the cursor (to 0,0), the
// button history and the registers (3-byte mode, 640 x 480). While rsp_tready
// is low the event word holds and bytes keep flowing until the queue fills.
module ps2_mouse_packet_decoder #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ps2m_pkg::BYTE_W-1:0]          req_tdata,   // data_byte
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pos_x, pos_y, delta_x, delta_y, wheel_step, button_mask,
   // pressed_mask, released_mask, zero pad
   output logic [((2*COORD_BITS+27+7)/8)*8-1:0] rsp_tdata,
   // configuration
   input  logic                                 csr_we,
   input  logic [ps2m_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ps2m_pkg::BOUND_W-1:0]         csr_wdata
);

   localparam int RSP_W = ((2*COORD_BITS+27+7)/8)*8;

   logic                              wheel_mode_ff, wheel_mode_in;
   logic [ps2m_pkg::BOUND_W-1:0]      bound_w_ff, bound_w_in;
   logic [ps2m_pkg::BOUND_W-1:0]      bound_h_ff, bound_h_in;
   logic                              recentre_ff, recentre_in;
   ps2m_pkg::cfg_type                 cfg;
   ps2m_pkg::pkt_type                 push_pkt;
   ps2m_pkg::pkt_type                 pop_pkt;
   ps2m_pkg::fifo_stat_type           q_stat;
   logic                              accept;
   logic                              push;
   logic                              pop;
   logic [COORD_BITS-1:0]             pos_x, pos_y;
   logic [ps2m_pkg::BYTE_W-1:0]       delta_x, delta_y;
   logic [ps2m_pkg::WHEEL_W-1:0]      wheel_step;
   logic [ps2m_pkg::BTN_W-1:0]        button_mask, pressed_mask, released_mask;

   // register writes
   always_comb begin
      wheel_mode_in = wheel_mode_ff;
      bound_w_in    = bound_w_ff;
      bound_h_in    = bound_h_ff;
      recentre_in   = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            ps2m_pkg::REG_WHEEL_MODE: begin
               wheel_mode_in = csr_wdata[0];
            end
            ps2m_pkg::REG_BOUND_WIDTH: begin
               bound_w_in  = csr_wdata;
               recentre_in = 1'b1;
            end
            ps2m_pkg::REG_BOUND_HEIGHT: begin
               bound_h_in  = csr_wdata;
               recentre_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_mode_ff <= 1'b0;
         bound_w_ff    <= ps2m_pkg::WIDTH_RESET;
         bound_h_ff    <= ps2m_pkg::HEIGHT_RESET;
         recentre_ff   <= 1'b0;
      end else begin
         wheel_mode_ff <= wheel_mode_in;
         bound_w_ff    <= bound_w_in;
         bound_h_ff    <= bound_h_in;
         recentre_ff   <= recentre_in;
      end
   end

   assign cfg.recentre = recentre_ff;
   assign cfg.bound_w  = bound_w_ff;
   assign cfg.bound_h  = bound_h_ff;

   // input handshake
   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   ps2m_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .wheel_mode (wheel_mode_ff),
      .push       (push),
      .push_pkt   (push_pkt)
   );

   ps2m_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .pop_pkt  (pop_pkt),
      .stat     (q_stat)
   );

   ps2m_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_valid       (!q_stat.empty),
      .q_pkt         (pop_pkt),
      .pop           (pop),
      .out_ready     (rsp_tready),
      .out_valid     (rsp_tvalid),
      .pos_x         (pos_x),
      .pos_y         (pos_y),
      .delta_x       (delta_x),
      .delta_y       (delta_y),
      .wheel_step    (wheel_step),
      .button_mask   (button_mask),
      .pressed_mask  (pressed_mask),
      .released_mask (released_mask)
   );

   // result word packing, first field in the low bits
   assign rsp_tdata = RSP_W'({released_mask, pressed_mask, button_mask, wheel_step,
                              delta_y, delta_x, pos_y, pos_x});

`ifndef SYNTH
   // no event word survives a reset
   a_reset_clears_out: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // press and release masks agree with the held buttons
   a_button_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((pressed_mask & released_mask) == '0) &&
                     ((pressed_mask & ~button_mask) == '0) &&
                     ((released_mask & button_mask) == '0))
      else $error("button edge masks inconsistent");

   // wheel decode yields only -1, 0 or +1
   a_wheel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (wheel_step != 2'b10))
      else $error("illegal wheel step");
`endif

endmodule
